// File: hdl/ghq_pkg.sv
// shared types, constants and saturating arithmetic helpers for the
// generalized heterogeneity q slope block; no dependencies
package ghq_pkg;

  localparam int MAX_STUDIES = 256;
  localparam int CNT_W = $clog2(MAX_STUDIES + 1);
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ZERO_WEIGHT = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  localparam logic [5:0] SH_NONE = 6'd0;
  localparam logic [5:0] SH_Q16 = 6'd16;
  localparam logic [5:0] SH_Q32 = 6'd32;

  localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

  // one queued study: effect plus weight denominator
  typedef struct packed {
    logic signed [31:0] effect;
    logic [63:0]        denom;
    logic               last;
  } ghq_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WSEL, ST_WDIV, ST_LOAD, ST_MUL, ST_RND, ST_ACC,
    ST_FIN, ST_MDIV, ST_CMB1, ST_CMB2, ST_CMB3, ST_OUT
  } ghq_state_e;

  typedef enum logic [3:0] {
    OP_WE, OP_WEE, OP_WW, OP_WWE, OP_WWEE, OP_T1, OP_MU2, OP_QP, OP_DP
  } ghq_op_e;

  // magnitude of a signed 64-bit value
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  // saturate a 65-bit exact sum to int64, flag in the top bit
  function automatic logic [64:0] sat65(input logic signed [64:0] s);
    if (s[64] != s[63]) begin
      sat65 = s[64] ? {1'b1, INT64_MIN} : {1'b1, INT64_MAX};
    end else begin
      sat65 = {1'b0, s[63:0]};
    end
  endfunction

  function automatic logic [64:0] add_sat(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    add_sat = sat65(s);
  endfunction

  function automatic logic [64:0] sub_sat(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    sub_sat = sat65(s);
  endfunction

  // round half away from zero on a magnitude, shift, then sign and saturate
  function automatic logic [64:0] fx_round(input logic [127:0] prod,
                                           input logic [5:0]   sh,
                                           input logic         neg);
    logic [127:0] half;
    logic [127:0] p;
    logic [63:0]  lim;
    logic [63:0]  m;
    logic         sat;
    half = (sh == SH_NONE) ? 128'd0 : (128'd1 << (sh - 6'd1));
    p = (prod + half) >> sh;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    sat = (p[127:64] != 64'd0) || (p[63:0] > lim);
    m = sat ? lim : p[63:0];
    fx_round = {sat, neg ? (64'd0 - m) : m};
  endfunction

endpackage

// File: hdl/ghq_front.sv
// front end: accepts studies, squares the standard error and forms the
// weight denominator; depends on ghq_pkg
module ghq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  effect_i,
  input  logic [31:0]         std_error_i,
  input  logic                last_i,
  input  logic [31:0]         variance_offset_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output ghq_pkg::ghq_entry_t push_entry_o
);

  logic               s_valid_q, s_valid_d;
  logic signed [31:0] s_effect_q;
  logic [63:0]        s_sq_q;
  logic               s_last_q;
  logic [64:0]        denom_sum;
  logic               take;

  assign in_ready_o = !s_valid_q || push_ready_i;
  assign take = in_valid_i && in_ready_o;

  // stage valid
  always_comb begin
    s_valid_d = s_valid_q;
    if (take) begin
      s_valid_d = 1'b1;
    end else if (push_ready_i) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  // square of the standard error
  always_ff @(posedge clk_i) begin
    if (take) begin
      s_effect_q <= effect_i;
      s_sq_q     <= std_error_i * std_error_i;
      s_last_q   <= last_i;
    end
  end

  // denominator saturates at all ones
  assign denom_sum = {1'b0, s_sq_q} + {17'd0, variance_offset_i, 16'd0};

  always_comb begin
    push_entry_o.effect = s_effect_q;
    push_entry_o.denom  = denom_sum[64] ? {64{1'b1}} : denom_sum[63:0];
    push_entry_o.last   = s_last_q;
  end

  assign push_valid_o = s_valid_q;

endmodule

// File: hdl/ghq_fifo.sv
// short queue between front and back end
// depends on ghq_pkg
module ghq_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  ghq_pkg::ghq_entry_t push_entry_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output ghq_pkg::ghq_entry_t pop_entry_o
);

  ghq_pkg::ghq_entry_t            mem_q [ghq_pkg::Q_DEPTH];
  logic [ghq_pkg::Q_AW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [ghq_pkg::Q_AW:0]         fill_q;
  logic                           push, pop;

  assign push_ready_o = (fill_q != (ghq_pkg::Q_AW+1)'(ghq_pkg::Q_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_entry_o = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == ghq_pkg::Q_AW'(ghq_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == ghq_pkg::Q_AW'(ghq_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: hdl/ghq_div.sv
// bit-serial restoring divider, 128-bit dividend by 64-bit divisor,
// one quotient bit per cycle; no dependencies
module ghq_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] dividend_i,
  input  logic [63:0]  divisor_i,
  output logic         done_o,
  output logic [127:0] quot_o,
  output logic [63:0]  rem_o
);

  logic         busy_q, done_q;
  logic [6:0]   cnt_q;
  logic [127:0] nq_q;
  logic [63:0]  r_q, d_q;
  logic [63:0]  r_shift;
  logic         qbit;

  // one restoring step
  assign r_shift = {r_q[62:0], nq_q[127]};
  assign qbit = r_q[63] || (r_shift >= d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 7'd127) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out as quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q <= dividend_i;
      r_q  <= '0;
      d_q  <= divisor_i;
    end else if (busy_q) begin
      nq_q <= {nq_q[126:0], qbit};
      r_q  <= qbit ? (r_shift - d_q) : r_shift;
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q;
  assign rem_o  = r_q;

endmodule

// File: hdl/ghq_mul.sv
// 64 by 64 unsigned multiplier built from four 32 by 32 partial products
// over successive cycles; no dependencies
module ghq_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic         busy_q, done_q, pp_valid_q;
  logic [2:0]   step_q;
  logic [63:0]  a_q, b_q, pp_q;
  logic [6:0]   sh_q;
  logic [127:0] acc_q;
  logic [31:0]  a_half, b_half;

  // partial product operand select
  assign a_half = step_q[0] ? a_q[63:32] : a_q[31:0];
  assign b_half = step_q[1] ? b_q[63:32] : b_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
      pp_valid_q <= 1'b0;
      step_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q     <= 1'b1;
        step_q     <= '0;
        pp_valid_q <= 1'b0;
      end else if (busy_q) begin
        step_q     <= step_q + 1'b1;
        pp_valid_q <= (step_q != 3'd4);
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // multiply then accumulate the shifted partial product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q <= a_half * b_half;
      sh_q <= {step_q[0] & step_q[1], step_q[0] ^ step_q[1], 5'd0};
      if (pp_valid_q) begin
        acc_q <= acc_q + ({64'd0, pp_q} << sh_q);
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: hdl/ghq_back.sv
// back end: weight, per-study products, saturating sums and the final
// q and slope; depends on ghq_pkg, ghq_div, ghq_mul
module ghq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  ghq_pkg::ghq_entry_t q_entry_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [62:0]         q_value_o,
  output logic signed [63:0]  dq_value_o,
  output logic [8:0]          study_count_o,
  output logic [1:0]          status_o
);

  ghq_pkg::ghq_state_e state_q, state_d;
  ghq_pkg::ghq_op_e    op_q, op_d;

  logic signed [31:0] e_q;
  logic [63:0]        denom_q;
  logic               last_q;
  logic [31:0]        w_q;
  logic [ghq_pkg::CNT_W-1:0] count_q;
  logic               sat_q;
  logic signed [63:0] s_w_q, s_we_q, s_wee_q, s_ww_q, s_wwe_q, s_wwee_q;
  logic signed [63:0] we_q, wee_q, ww_q, wwe_q, wwee_q;
  logic signed [63:0] mu_q, t1_q, mu2_q, qp_q, dp_q;
  logic signed [63:0] q_q, dq1_q, tt_q, dq2_q;
  logic               neg_q;
  logic [62:0]        res_q_q;
  logic signed [63:0] res_dq_q;
  logic [1:0]         res_st_q;

  logic               div_start, div_done;
  logic [127:0]       div_dividend, div_quot;
  logic [63:0]        div_divisor, div_rem;
  logic               mul_start, mul_done;
  logic [127:0]       mul_prod;
  logic signed [63:0] opa, opb;
  logic [5:0]         op_sh;
  logic [64:0]        rnd;
  logic [64:0]        mu_r;
  logic [127:0]       mu_q128;
  logic [64:0]        a_w, a_we, a_wee, a_ww, a_wwe, a_wwee;
  logic [64:0]        c_q, c_dq1, c_tt, c_dq2, c_dq;
  logic [63:0]        wnum;

  ghq_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_dividend), .divisor_i(div_divisor),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  ghq_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start), .a_i(ghq_pkg::mag64(opa)), .b_i(ghq_pkg::mag64(opb)),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  // operands of the current product
  always_comb begin
    opa = '0;
    opb = '0;
    op_sh = ghq_pkg::SH_NONE;
    case (op_q)
      ghq_pkg::OP_WE:   begin opa = {32'd0, w_q}; opb = 64'(e_q); end
      ghq_pkg::OP_WEE:  begin opa = we_q; opb = 64'(e_q); op_sh = ghq_pkg::SH_Q16; end
      ghq_pkg::OP_WW:   begin opa = {32'd0, w_q}; opb = {32'd0, w_q}; end
      ghq_pkg::OP_WWE:  begin opa = {32'd0, w_q}; opb = we_q; op_sh = ghq_pkg::SH_Q16; end
      ghq_pkg::OP_WWEE: begin opa = {32'd0, w_q}; opb = wee_q; op_sh = ghq_pkg::SH_Q16; end
      ghq_pkg::OP_T1:   begin opa = mu_q; opb = s_wwe_q; op_sh = ghq_pkg::SH_Q32; end
      ghq_pkg::OP_MU2:  begin opa = mu_q; opb = mu_q; op_sh = ghq_pkg::SH_Q32; end
      ghq_pkg::OP_QP:   begin opa = s_we_q; opb = mu_q; op_sh = ghq_pkg::SH_Q32; end
      ghq_pkg::OP_DP:   begin opa = mu2_q; opb = s_ww_q; op_sh = ghq_pkg::SH_Q32; end
      default: ;
    endcase
  end

  assign rnd = ghq_pkg::fx_round(mul_prod, op_sh, neg_q);

  // mean with round half away from zero
  assign mu_q128 = div_quot + {127'd0, (div_rem >= (s_w_q - div_rem))};
  assign mu_r = ghq_pkg::fx_round(mu_q128, ghq_pkg::SH_NONE, s_we_q[63]);

  // per-study saturating sums
  assign a_w    = ghq_pkg::add_sat(s_w_q, {16'd0, w_q, 16'd0});
  assign a_we   = ghq_pkg::add_sat(s_we_q, we_q);
  assign a_wee  = ghq_pkg::add_sat(s_wee_q, wee_q);
  assign a_ww   = ghq_pkg::add_sat(s_ww_q, ww_q);
  assign a_wwe  = ghq_pkg::add_sat(s_wwe_q, wwe_q);
  assign a_wwee = ghq_pkg::add_sat(s_wwee_q, wwee_q);

  // final combination steps
  assign c_q   = ghq_pkg::sub_sat(s_wee_q, qp_q);
  assign c_dq1 = ghq_pkg::sub_sat(64'sd0, s_wwee_q);
  assign c_tt  = ghq_pkg::add_sat(t1_q, t1_q);
  assign c_dq2 = ghq_pkg::add_sat(dq1_q, tt_q);
  assign c_dq  = ghq_pkg::sub_sat(dq2_q, dp_q);

  assign wnum = 64'h0001_0000_0000_0000 + {1'b0, denom_q[63:1]};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ghq_pkg::ST_IDLE: if (q_valid_i) state_d = ghq_pkg::ST_WSEL;
      ghq_pkg::ST_WSEL: begin
        if (count_q >= ghq_pkg::CNT_W'(ghq_pkg::MAX_STUDIES)) begin
          state_d = ghq_pkg::ST_FIN;
        end else if (denom_q == '0) begin
          state_d = ghq_pkg::ST_LOAD;
        end else begin
          state_d = ghq_pkg::ST_WDIV;
        end
      end
      ghq_pkg::ST_WDIV: if (div_done) state_d = ghq_pkg::ST_LOAD;
      ghq_pkg::ST_LOAD: state_d = ghq_pkg::ST_MUL;
      ghq_pkg::ST_MUL:  if (mul_done) state_d = ghq_pkg::ST_RND;
      ghq_pkg::ST_RND: begin
        if (op_q == ghq_pkg::OP_WWEE) begin
          state_d = ghq_pkg::ST_ACC;
        end else if (op_q == ghq_pkg::OP_DP) begin
          state_d = ghq_pkg::ST_CMB1;
        end else begin
          state_d = ghq_pkg::ST_LOAD;
        end
      end
      ghq_pkg::ST_ACC: state_d = ghq_pkg::ST_FIN;
      ghq_pkg::ST_FIN: begin
        if (!last_q) begin
          state_d = ghq_pkg::ST_IDLE;
        end else if (s_w_q <= 64'sd0) begin
          state_d = ghq_pkg::ST_OUT;
        end else begin
          state_d = ghq_pkg::ST_MDIV;
        end
      end
      ghq_pkg::ST_MDIV: if (div_done) state_d = ghq_pkg::ST_LOAD;
      ghq_pkg::ST_CMB1: state_d = ghq_pkg::ST_CMB2;
      ghq_pkg::ST_CMB2: state_d = ghq_pkg::ST_CMB3;
      ghq_pkg::ST_CMB3: state_d = ghq_pkg::ST_OUT;
      ghq_pkg::ST_OUT:  if (out_ready_i) state_d = ghq_pkg::ST_IDLE;
      default: state_d = ghq_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_ready_o    = 1'b0;
    div_start    = 1'b0;
    mul_start    = 1'b0;
    out_valid_o  = 1'b0;
    div_dividend = {64'd0, wnum};
    div_divisor  = denom_q;
    unique case (state_q)
      ghq_pkg::ST_IDLE: q_ready_o = 1'b1;
      ghq_pkg::ST_WSEL: begin
        div_start = (count_q < ghq_pkg::CNT_W'(ghq_pkg::MAX_STUDIES)) && (denom_q != '0);
      end
      ghq_pkg::ST_FIN: begin
        div_dividend = {32'd0, ghq_pkg::mag64(s_we_q), 32'd0};
        div_divisor  = s_w_q;
        div_start    = last_q && (s_w_q > 64'sd0);
      end
      ghq_pkg::ST_LOAD: mul_start = 1'b1;
      ghq_pkg::ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // next product
  always_comb begin
    op_d = op_q;
    case (state_q)
      ghq_pkg::ST_WSEL, ghq_pkg::ST_WDIV: op_d = ghq_pkg::OP_WE;
      ghq_pkg::ST_MDIV: op_d = ghq_pkg::OP_T1;
      ghq_pkg::ST_RND: begin
        case (op_q)
          ghq_pkg::OP_WE:  op_d = ghq_pkg::OP_WEE;
          ghq_pkg::OP_WEE: op_d = ghq_pkg::OP_WW;
          ghq_pkg::OP_WW:  op_d = ghq_pkg::OP_WWE;
          ghq_pkg::OP_WWE: op_d = ghq_pkg::OP_WWEE;
          ghq_pkg::OP_T1:  op_d = ghq_pkg::OP_MU2;
          ghq_pkg::OP_MU2: op_d = ghq_pkg::OP_QP;
          ghq_pkg::OP_QP:  op_d = ghq_pkg::OP_DP;
          default: op_d = op_q;
        endcase
      end
      default: ;
    endcase
  end

  // control registers and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ghq_pkg::ST_IDLE;
      op_q     <= ghq_pkg::OP_WE;
      count_q  <= '0;
      sat_q    <= 1'b0;
      s_w_q    <= '0;
      s_we_q   <= '0;
      s_wee_q  <= '0;
      s_ww_q   <= '0;
      s_wwe_q  <= '0;
      s_wwee_q <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      case (state_q)
        ghq_pkg::ST_WSEL: begin
          if (count_q >= ghq_pkg::CNT_W'(ghq_pkg::MAX_STUDIES) || denom_q == '0) begin
            sat_q <= 1'b1;
          end
        end
        ghq_pkg::ST_WDIV: if (div_done && div_quot[127:32] != '0) sat_q <= 1'b1;
        ghq_pkg::ST_RND:  if (rnd[64]) sat_q <= 1'b1;
        ghq_pkg::ST_MDIV: if (div_done && mu_r[64]) sat_q <= 1'b1;
        ghq_pkg::ST_ACC: begin
          s_w_q    <= a_w[63:0];
          s_we_q   <= a_we[63:0];
          s_wee_q  <= a_wee[63:0];
          s_ww_q   <= a_ww[63:0];
          s_wwe_q  <= a_wwe[63:0];
          s_wwee_q <= a_wwee[63:0];
          count_q  <= count_q + 1'b1;
          if (a_w[64] || a_we[64] || a_wee[64] || a_ww[64] || a_wwe[64] || a_wwee[64]) begin
            sat_q <= 1'b1;
          end
        end
        ghq_pkg::ST_CMB1: if (c_q[64] || c_dq1[64] || c_tt[64]) sat_q <= 1'b1;
        ghq_pkg::ST_CMB2: if (c_dq2[64]) sat_q <= 1'b1;
        ghq_pkg::ST_OUT: begin
          if (out_ready_i) begin
            count_q  <= '0;
            sat_q    <= 1'b0;
            s_w_q    <= '0;
            s_we_q   <= '0;
            s_wee_q  <= '0;
            s_ww_q   <= '0;
            s_wwe_q  <= '0;
            s_wwee_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ghq_pkg::ST_IDLE: begin
        e_q     <= q_entry_i.effect;
        denom_q <= q_entry_i.denom;
        last_q  <= q_entry_i.last;
      end
      ghq_pkg::ST_WSEL: w_q <= 32'hFFFF_FFFF;
      ghq_pkg::ST_WDIV: begin
        if (div_done) begin
          w_q <= (div_quot[127:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
        end
      end
      ghq_pkg::ST_LOAD: neg_q <= opa[63] ^ opb[63];
      ghq_pkg::ST_RND: begin
        case (op_q)
          ghq_pkg::OP_WE:   we_q   <= rnd[63:0];
          ghq_pkg::OP_WEE:  wee_q  <= rnd[63:0];
          ghq_pkg::OP_WW:   ww_q   <= rnd[63:0];
          ghq_pkg::OP_WWE:  wwe_q  <= rnd[63:0];
          ghq_pkg::OP_WWEE: wwee_q <= rnd[63:0];
          ghq_pkg::OP_T1:   t1_q   <= rnd[63:0];
          ghq_pkg::OP_MU2:  mu2_q  <= rnd[63:0];
          ghq_pkg::OP_QP:   qp_q   <= rnd[63:0];
          ghq_pkg::OP_DP:   dp_q   <= rnd[63:0];
          default: ;
        endcase
      end
      ghq_pkg::ST_FIN: begin
        res_q_q  <= '0;
        res_dq_q <= '0;
        res_st_q <= ghq_pkg::STATUS_ZERO_WEIGHT;
      end
      ghq_pkg::ST_MDIV: if (div_done) mu_q <= mu_r[63:0];
      ghq_pkg::ST_CMB1: begin
        q_q   <= c_q[63] ? 64'sd0 : c_q[63:0];
        dq1_q <= c_dq1[63:0];
        tt_q  <= c_tt[63:0];
      end
      ghq_pkg::ST_CMB2: dq2_q <= c_dq2[63:0];
      ghq_pkg::ST_CMB3: begin
        res_q_q  <= q_q[62:0];
        res_dq_q <= c_dq[63:0];
        res_st_q <= (sat_q || c_dq[64]) ? ghq_pkg::STATUS_SATURATED : ghq_pkg::STATUS_OK;
      end
      default: ;
    endcase
  end

  assign q_value_o     = res_q_q;
  assign dq_value_o    = res_dq_q;
  assign study_count_o = 9'(count_q);
  assign status_o      = res_st_q;

endmodule

// File: hdl/generalized_heterogeneity_q_slope.sv
// generalized heterogeneity q and slope: front end, study queue, back end
// back end: a study runs a serial weight divide (none for a zero denominator)
// and five products on the shared 32x32 multiplier; a last study with positive
// total weight adds a serial mean divide and four products; the back end takes
// a new study only after it is through with the previous one
// reset: asynchronous active low, clears sums, count, flag, queue and offset
module generalized_heterogeneity_q_slope (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] effect_i,
  input  logic [31:0]        std_error_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [62:0]        q_value_o,
  output logic signed [63:0] dq_value_o,
  output logic [8:0]         study_count_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);

  logic [31:0]         variance_offset_q;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  ghq_pkg::ghq_entry_t push_entry, pop_entry;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variance_offset_q <= '0;
    end else if (cfg_valid_i) begin
      variance_offset_q <= cfg_data_i;
    end
  end

  ghq_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .effect_i, .std_error_i, .last_i,
    .variance_offset_i(variance_offset_q),
    .push_valid_o(push_valid), .push_ready_i(push_ready), .push_entry_o(push_entry)
  );

  ghq_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_ready_o(push_ready), .push_entry_i(push_entry),
    .pop_valid_o(pop_valid), .pop_ready_i(pop_ready), .pop_entry_o(pop_entry)
  );

  ghq_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(pop_valid), .q_ready_o(pop_ready), .q_entry_i(pop_entry),
    .out_valid_o, .out_ready_i, .q_value_o, .dq_value_o, .study_count_o, .status_o
  );

endmodule

// File: hdl/ghq_checker.sv
// port-level checks on the result channel of the top level
// depends on generalized_heterogeneity_q_slope, attached by bind
module ghq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [62:0]        q_value_o,
  input logic signed [63:0] dq_value_o,
  input logic [8:0]         study_count_o,
  input logic [1:0]         status_o
);

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transaction");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(q_value_o) && $stable(dq_value_o)
      && $stable(status_o) && $stable(study_count_o))
    else $error("result payload changed while stalled");

  // zero total weight gives zero outputs
  a_zero_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ghq_pkg::STATUS_ZERO_WEIGHT |->
      q_value_o == '0 && dq_value_o == '0)
    else $error("zero weight result not cleared");

  // every result has a nonzero study count and a defined status
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> study_count_o != '0 && status_o != 2'd3)
    else $error("bad count or status on result");

endmodule

bind generalized_heterogeneity_q_slope ghq_checker u_ghq_checker (.*);
